### hw/rtl/cdeq_pkg.sv
// Shared types and constants for the circular double-ended queue.
package cdeq_pkg;

  localparam int unsigned DepthDef   = 16;
  localparam int unsigned DataWDef   = 32;
  localparam int unsigned PopW       = 32;
  localparam int unsigned CntFieldW  = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [PopW-1:0]   push_value;
  } in_t;

  typedef struct packed {
    logic [PopW-1:0]      pop_value;
    status_e              status;
    logic [CntFieldW-1:0] entry_count;
  } out_t;

endpackage

### hw/rtl/cdeq_ring.sv
// Single-port ring storage with a registered read port.
module cdeq_ring #(
  parameter int unsigned DEPTH      = cdeq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdeq_pkg::DataWDef,
  localparam int unsigned IdxW      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);
  import cdeq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read, so a stalled result stays put.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/circular_double_ended_queue_top.sv
// Top level of the circular double-ended queue, with ring storage and index control.
//
// This block is a double-ended queue kept in a ring of DEPTH words. Each input
// item asks to push a word at the front or back, or to pop one from the front
// or back, and produces exactly one result item carrying the popped word (zero
// for pushes and failed pops), a status and the entry count after the request.
// A push on a full queue is refused with status full and a pop on an empty
// queue returns status empty; neither changes anything. The ring lives in a
// single-port synchronous memory: the accepting cycle computes the slot from
// the front index and count registers and issues the write or read, and the
// result item appears in the cycle after acceptance. One item is taken every
// cycle as long as the output side keeps taking results; the registered
// result can be handed off at the same edge a new item enters. A push followed
// by a pop of the same slot needs no forwarding, since the write finishes at
// the edge before the read is issued.
module circular_double_ended_queue_top #(
  parameter int unsigned DEPTH      = cdeq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdeq_pkg::DataWDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cdeq_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cdeq_pkg::out_t out_data_o
);
  import cdeq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);
  localparam logic [CntW:0]   DepthExt = (CntW + 1)'(DEPTH);

  // Index state.
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic            pop_ok_q, pop_ok_d;

  logic            accept;
  logic            is_full, is_empty;
  logic [IdxW-1:0] front_inc, front_dec;
  logic [CntW:0]   amount, front_ext, back_diff, back_wrap;
  logic [IdxW-1:0] back_slot;

  logic                  wr_en, rd_en;
  logic [IdxW-1:0]       addr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [DATA_WIDTH+PopW-1:0] push_wide;
  logic [DATA_WIDTH+PopW-1:0] pop_wide;
  logic [CntW+CntFieldW-1:0]  cnt_wide;

  // A new item may enter whenever the result register is empty or is being
  // taken at this edge.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == FullCnt);
  assign is_empty = (count_q == '0);

  assign front_inc = (front_q == LastSlot) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastSlot : front_q - 1'b1;

  // The back slot lies count+1 below the front for a push and count below it
  // for a pop; one subtract and one wrap correction cover both.
  assign amount    = (in_data_i.req_type == REQ_PUSH_BACK) ?
                     ({1'b0, count_q} + 1'b1) : {1'b0, count_q};
  assign front_ext = (CntW + 1)'(front_q);
  assign back_diff = front_ext - amount;
  assign back_wrap = back_diff[CntW] ? back_diff + DepthExt : back_diff;
  assign back_slot = back_wrap[IdxW-1:0];

  // Stored words are kept to DATA_WIDTH bits.
  assign push_wide = {{DATA_WIDTH{1'b0}}, in_data_i.push_value};
  assign wdata     = push_wide[DATA_WIDTH-1:0];

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    addr        = front_q;
    status_d    = status_q;
    pop_ok_d    = pop_ok_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_DONE;
      pop_ok_d    = 1'b0;
      unique case (in_data_i.req_type)
        REQ_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            addr    = front_q;
            front_d = front_inc;
            count_d = count_q + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            addr    = back_slot;
            count_d = count_q + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            pop_ok_d = 1'b1;
            addr     = front_dec;
            front_d  = front_dec;
            count_d  = count_q - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            pop_ok_d = 1'b1;
            addr     = back_slot;
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; it only changes when a new item is accepted.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pop_ok_q <= pop_ok_d;
  end

  cdeq_ring #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ring (
    .clk_i   (clk_i),
    .wr_en_i (wr_en),
    .rd_en_i (rd_en),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // The entry count of the result is the count register after the request.
  assign pop_wide = {{PopW{1'b0}}, rdata};
  assign cnt_wide = {{CntFieldW{1'b0}}, count_q};

  assign out_valid_o            = out_valid_q;
  assign out_data_o.pop_value   = pop_ok_q ? pop_wide[PopW-1:0] : '0;
  assign out_data_o.status      = status_q;
  assign out_data_o.entry_count = cnt_wide[CntFieldW-1:0];

endmodule
